// ----- hdl/piecewise_distance_force_response_macros.svh -----
// Assertion macros for the piecewise distance force response block.
// Included by the top level; no other dependencies.
`ifndef PIECEWISE_DISTANCE_FORCE_RESPONSE_MACROS_SVH
`define PIECEWISE_DISTANCE_FORCE_RESPONSE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PDFR_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// next-cycle implication
`define PDFR_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define PDFR_ASSERT_IMP(label, clk, rst_n, pre, post, msg)
`define PDFR_ASSERT_NXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- hdl/pdfr_pkg.sv -----
// Shared types, widths and helpers of the piecewise distance force response.
// No dependencies.
`timescale 1ns / 1ps
package pdfr_pkg;

    localparam int FRAC_W    = 12;
    localparam int DIST_W    = 16;
    localparam int MAXD_W    = 15;
    localparam int BLEND_W   = 14;
    localparam int FORCE_W   = 18;
    localparam int RESP_W    = 20;
    localparam int REGION_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 18;
    localparam int CONTACT_W = FORCE_W + 2;

    // divider: numerator holds 2^(2F)+x/2 and u<<F
    localparam int NUM_W      = MAXD_W + FRAC_W;
    localparam int DEN_W      = MAXD_W;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;

    // curve datapath
    localparam int REC_W = 2 * FRAC_W + 1;
    localparam int T_W   = FRAC_W + 1;
    localparam int FF_W  = 2 * REC_W - FRAC_W;
    localparam int G_W   = FF_W + BLEND_W - FRAC_W;
    localparam int H_W   = FRAC_W + 4;
    localparam int P1_W  = REC_W + 1 + H_W;
    localparam int P2_W  = G_W + 1 + H_W;
    localparam int SUM_W = P2_W + 1;

    localparam int PIPE_LAT = DIV_STAGES + 5;

    localparam logic [RESP_W-1:0]  RESP_MAX       = '1;
    localparam logic [MAXD_W-1:0]  MAXD_RESET     = MAXD_W'(8192);
    localparam logic [BLEND_W-1:0] BLEND_RESET    = BLEND_W'(410);
    localparam logic [FORCE_W-1:0] FORCE_RESET    = FORCE_W'(12288);

    typedef enum logic [REGION_W-1:0] {
        REGION_FAR,
        REGION_OUTER,
        REGION_INVERSE,
        REGION_INNER,
        REGION_CONTACT
    } region_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DISTANCE,
        CFG_BLEND_WIDTH,
        CFG_FORCE_LIMIT
    } cfg_index_t;

    typedef struct packed {
        logic [MAXD_W-1:0]  max_distance;
        logic [BLEND_W-1:0] blend_width;
        logic [FORCE_W-1:0] force_limit;
    } cfg_t;

    typedef struct packed {
        region_t           region;
        logic [NUM_W-1:0]  rec_num;
        logic [DEN_W-1:0]  rec_den;
        logic [NUM_W-1:0]  t_num;
        logic [DEN_W-1:0]  t_den;
    } front_t;

    // effective blend width: never more than half the max distance
    function automatic logic [BLEND_W-1:0] eff_blend(input cfg_t cfg);
        logic [BLEND_W-1:0] half;
        half = cfg.max_distance[MAXD_W-1:1];
        if (cfg.blend_width > half)
            return half;
        return cfg.blend_width;
    endfunction

endpackage

// ----- hdl/pdfr_front.sv -----
// Region classifier and divider operand setup, one register stage.
// Depends on pdfr_pkg.
`timescale 1ns / 1ps
module pdfr_front (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [pdfr_pkg::DIST_W-1:0]  distance,
    input  pdfr_pkg::cfg_t                      cfg,
    output pdfr_pkg::front_t                    front
);
    import pdfr_pkg::*;

    logic [BLEND_W-1:0]      b;
    logic [MAXD_W-1:0]       r;
    logic signed [DIST_W:0]  d_ext;
    logic [MAXD_W-1:0]       d_pos;
    logic [MAXD_W-1:0]       x;
    logic [MAXD_W-1:0]       u;
    front_t                  front_next;
    front_t                  front_reg;

    // classify and pick divider operands
    always_comb
    begin
        b     = eff_blend(cfg);
        r     = cfg.max_distance - MAXD_W'(b);
        d_ext = {distance[DIST_W-1], distance};
        d_pos = distance[MAXD_W-1:0];
        if (d_ext >= $signed({2'b00, cfg.max_distance}))
            front_next.region = REGION_FAR;
        else if (d_ext <= 0)
            front_next.region = REGION_CONTACT;
        else if (d_ext > $signed({2'b00, r}))
            front_next.region = REGION_OUTER;
        else if (d_ext > $signed({3'b000, b}))
            front_next.region = REGION_INVERSE;
        else
            front_next.region = REGION_INNER;

        case (front_next.region)
            REGION_OUTER:
            begin
                x = r;
                u = d_pos - r;
            end
            REGION_INNER:
            begin
                x = MAXD_W'(b);
                u = d_pos;
            end
            default:
            begin
                x = d_pos;
                u = d_pos;
            end
        endcase

        // reciprocal rounded to nearest: (2^(2F) + x/2) / x
        front_next.rec_num = (NUM_W'(1) << (2 * FRAC_W)) + NUM_W'(x >> 1);
        front_next.rec_den = x;
        // blend parameter: (u << F) / B
        front_next.t_num   = NUM_W'(u) << FRAC_W;
        front_next.t_den   = DEN_W'(b);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            front_reg <= front_next;
    end

    assign front = front_reg;

endmodule

// ----- hdl/pdfr_div.sv -----
// Pipelined restoring divider, DIV_STEPS quotient bits per stage.
// Depends on pdfr_pkg.
`timescale 1ns / 1ps
module pdfr_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [pdfr_pkg::NUM_W-1:0]    num,
    input  logic [pdfr_pkg::DEN_W-1:0]    den,
    output logic [pdfr_pkg::NUM_W-1:0]    quo
);
    import pdfr_pkg::*;

    logic [NUM_W-1:0] num_reg [DIV_STAGES];
    logic [NUM_W-1:0] quo_reg [DIV_STAGES];
    logic [DEN_W:0]   rem_reg [DIV_STAGES];
    logic [DEN_W-1:0] den_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [NUM_W-1:0] num_in;
        logic [NUM_W-1:0] quo_in;
        logic [DEN_W:0]   rem_in;
        logic [DEN_W-1:0] den_in;
        logic [NUM_W-1:0] num_next;
        logic [NUM_W-1:0] quo_next;
        logic [DEN_W:0]   rem_next;

        if (s == 0)
        begin : g_first
            assign num_in = num;
            assign quo_in = '0;
            assign rem_in = '0;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign num_in = num_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        // shift in one numerator bit, trial subtract, per step
        always_comb
        begin
            num_next = num_in;
            quo_next = quo_in;
            rem_next = rem_in;
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                rem_next = {rem_next[DEN_W-1:0], num_next[NUM_W-1]};
                num_next = num_next << 1;
                quo_next = quo_next << 1;
                if (rem_next >= {1'b0, den_in})
                begin
                    rem_next    = rem_next - {1'b0, den_in};
                    quo_next[0] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[s] <= num_next;
                quo_reg[s] <= quo_next;
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_in;
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

// ----- hdl/pdfr_poly.sv -----
// Hermite blend evaluation and result selection, four register stages.
// Depends on pdfr_pkg.
`timescale 1ns / 1ps
module pdfr_poly (
    input  logic                           clk,
    input  logic                           en,
    input  pdfr_pkg::region_t              region_in,
    input  logic [pdfr_pkg::REC_W-1:0]     rec,
    input  logic [pdfr_pkg::T_W-1:0]       t,
    input  pdfr_pkg::cfg_t                 cfg,
    output logic [pdfr_pkg::RESP_W-1:0]    response,
    output pdfr_pkg::region_t              region
);
    import pdfr_pkg::*;

    function automatic logic [RESP_W-1:0] sat_resp(input logic [SUM_W-1:0] v);
        if (|v[SUM_W-1:RESP_W])
            return RESP_MAX;
        return v[RESP_W-1:0];
    endfunction

    logic [CONTACT_W-1:0] contact;
    logic [BLEND_W-1:0]   b;

    // stage 1: t^2, f^2
    region_t            region1_reg;
    logic [REC_W-1:0]   rec1_reg;
    logic [T_W-1:0]     t1_reg;
    logic [T_W-1:0]     t2_1_reg;
    logic [FF_W-1:0]    ff1_reg;
    logic [2*T_W-1:0]   tt_prod;
    logic [2*REC_W-1:0] ff_prod;

    // stage 2: t^3, g
    region_t                    region2_reg;
    logic [REC_W-1:0]           rec2_reg;
    logic [T_W-1:0]             t2_reg;
    logic [T_W-1:0]             t2_2_reg;
    logic [T_W-1:0]             t3_2_reg;
    logic [G_W-1:0]             g2_reg;
    logic [2*T_W-1:0]           ttt_prod;
    logic [FF_W+BLEND_W-1:0]    g_prod;

    // stage 3: basis products
    region_t                 region3_reg;
    logic [REC_W-1:0]        rec3_reg;
    logic signed [P1_W-1:0]  p1_reg;
    logic signed [P2_W-1:0]  p2_reg;
    logic [H_W-1:0]          h1;
    logic [H_W-1:0]          h3;
    logic [H_W-1:0]          k;
    logic [REC_W-1:0]        a1;
    logic [G_W-1:0]          a2;
    logic [H_W-1:0]          c2;
    logic signed [P1_W-1:0]  p1_next;
    logic signed [P2_W-1:0]  p2_next;

    // stage 4: sum, clamp, output register
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]        sum_sh;
    logic [RESP_W-1:0]       response_next;
    logic [RESP_W-1:0]       response_reg;
    region_t                 region_reg;

    assign contact = CONTACT_W'({cfg.force_limit, 1'b0}) + CONTACT_W'(cfg.force_limit);
    assign b       = eff_blend(cfg);

    assign tt_prod = (2*T_W)'(t) * (2*T_W)'(t);
    assign ff_prod = (2*REC_W)'(rec) * (2*REC_W)'(rec);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            region1_reg <= region_in;
            rec1_reg    <= rec;
            t1_reg      <= t;
            t2_1_reg    <= tt_prod[FRAC_W+T_W-1:FRAC_W];
            ff1_reg     <= ff_prod[FRAC_W+FF_W-1:FRAC_W];
        end
    end

    assign ttt_prod = (2*T_W)'(t2_1_reg) * (2*T_W)'(t1_reg);
    assign g_prod   = (FF_W+BLEND_W)'(ff1_reg) * (FF_W+BLEND_W)'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            region2_reg <= region1_reg;
            rec2_reg    <= rec1_reg;
            t2_reg      <= t1_reg;
            t2_2_reg    <= t2_1_reg;
            t3_2_reg    <= ttt_prod[FRAC_W+T_W-1:FRAC_W];
            g2_reg      <= g_prod[FRAC_W+G_W-1:FRAC_W];
        end
    end

    // Hermite basis values, two's complement in H_W bits
    always_comb
    begin
        h1 = (H_W'(t3_2_reg) << 1) - (H_W'(t2_2_reg) << 1) - H_W'(t2_2_reg)
             + (H_W'(1) << FRAC_W);
        h3 = H_W'(t3_2_reg) - (H_W'(t2_2_reg) << 1) + H_W'(t2_reg);
        k  = (H_W'(t2_2_reg) << 2) - (H_W'(t3_2_reg) << 1) - H_W'(t3_2_reg);
        if (region2_reg == REGION_OUTER)
        begin
            a1 = rec2_reg;
            a2 = g2_reg;
            c2 = h3;
        end
        else
        begin
            a1 = REC_W'(contact);
            a2 = G_W'(rec2_reg);
            c2 = k;
        end
        p1_next = $signed({1'b0, a1}) * $signed(h1);
        p2_next = $signed({1'b0, a2}) * $signed(c2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            region3_reg <= region2_reg;
            rec3_reg    <= rec2_reg;
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
        end
    end

    // outer blend subtracts the slope term, inner adds
    always_comb
    begin
        if (region3_reg == REGION_OUTER)
            sum = SUM_W'(p1_reg) - SUM_W'(p2_reg);
        else
            sum = SUM_W'(p1_reg) + SUM_W'(p2_reg);
        sum_sh = $unsigned(sum >>> FRAC_W);
        case (region3_reg)
            REGION_FAR:     response_next = '0;
            REGION_CONTACT: response_next = sat_resp(SUM_W'(contact));
            REGION_INVERSE: response_next = sat_resp(SUM_W'(rec3_reg));
            REGION_OUTER,
            REGION_INNER:
            begin
                if (sum < 0)
                    response_next = '0;
                else
                    response_next = sat_resp(sum_sh);
            end
            default:        response_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            response_reg <= response_next;
            region_reg   <= region3_reg;
        end
    end

    assign response = response_reg;
    assign region   = region_reg;

endmodule

// ----- hdl/piecewise_distance_force_response.sv -----
// Throughput: one item per cycle while the output is not stalled; the 9-stage
// dividers for 1/x and the blend parameter and the 4 Hermite blend stages are
// fully pipelined. A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, asynchronous) clears the valid bits and loads the
// register defaults: max_distance 8192, blend_width 410, force_limit 12288.
`timescale 1ns / 1ps
`include "piecewise_distance_force_response_macros.svh"
module piecewise_distance_force_response (
    input  logic                               clk,
    input  logic                               rst_n,
    // s_tdata: [15:0] effective_distance
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,
    // m_tdata: [19:0] response, [23:20] zero
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,
    // m_tuser: [2:0] region
    output logic [2:0]                         m_tuser,
    input  logic                               cfg_we,
    input  logic [pdfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdfr_pkg::CFG_W-1:0]         cfg_data
);
    import pdfr_pkg::*;

    cfg_t               cfg_reg;
    logic               en;
    logic               vld_reg [PIPE_LAT];
    front_t             front;
    logic [NUM_W-1:0]   rec_q;
    logic [NUM_W-1:0]   t_q;
    region_t            region_pipe_reg [DIV_STAGES];
    logic [RESP_W-1:0]  response;
    region_t            region;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_distance <= MAXD_RESET;
            cfg_reg.blend_width  <= BLEND_RESET;
            cfg_reg.force_limit  <= FORCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_DISTANCE: cfg_reg.max_distance <= cfg_data[MAXD_W-1:0];
                CFG_BLEND_WIDTH:  cfg_reg.blend_width  <= cfg_data[BLEND_W-1:0];
                CFG_FORCE_LIMIT:  cfg_reg.force_limit  <= cfg_data[FORCE_W-1:0];
                default:          ;
            endcase
        end
    end

    // pipeline advances unless the output holds an untaken item
    assign en       = !vld_reg[PIPE_LAT-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < PIPE_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    pdfr_front u_front (
        .clk      (clk),
        .en       (en),
        .distance ($signed(s_tdata[DIST_W-1:0])),
        .cfg      (cfg_reg),
        .front    (front)
    );

    pdfr_div u_div_rec (
        .clk (clk),
        .en  (en),
        .num (front.rec_num),
        .den (front.rec_den),
        .quo (rec_q)
    );

    pdfr_div u_div_t (
        .clk (clk),
        .en  (en),
        .num (front.t_num),
        .den (front.t_den),
        .quo (t_q)
    );

    // region rides alongside the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            region_pipe_reg[0] <= front.region;
            for (int i = 1; i < DIV_STAGES; i++)
                region_pipe_reg[i] <= region_pipe_reg[i-1];
        end
    end

    pdfr_poly u_poly (
        .clk       (clk),
        .en        (en),
        .region_in (region_pipe_reg[DIV_STAGES-1]),
        .rec       (rec_q[REC_W-1:0]),
        .t         (t_q[T_W-1:0]),
        .cfg       (cfg_reg),
        .response  (response),
        .region    (region)
    );

    assign m_tvalid = vld_reg[PIPE_LAT-1];
    assign m_tdata  = {4'b0000, response};
    assign m_tuser  = region;

    `PDFR_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, !s_tready, m_tvalid, "stall without output item")
    `PDFR_ASSERT_IMP(a_far_is_zero, clk, rst_n, m_tvalid && (m_tuser == REGION_FAR), m_tdata[RESP_W-1:0] == '0, "far item with nonzero response")
    `PDFR_ASSERT_NXT(a_item_reaches_output, clk, rst_n, vld_reg[PIPE_LAT-2] && en, m_tvalid, "item lost before output")

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the piecewise distance force response block.
// Depends on pdfr_pkg and the piecewise_distance_force_response RTL only.
`timescale 1ns / 1ps
module testbench;
    import pdfr_pkg::*;

    localparam int F = FRAC_W;
    localparam longint RMAX = 1048575;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0] m_tuser;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    typedef struct packed {
        logic [RESP_W-1:0] response;
        region_t region;
    } force_item_t;

    force_item_t expected_q[$];
    longint max_dist, blend, flimit;
    int fails = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always #5 clk = ~clk;

    piecewise_distance_force_response dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // rounded reciprocal, clamped at 2^30
    function automatic longint reciprocal(longint x);
        longint q;
        if (x <= 0)
            return 64'd1 << 30;
        q = ((64'd1 << (2 * F)) + (x >> 1)) / x;
        return (q > (64'd1 << 30)) ? (64'd1 << 30) : q;
    endfunction

    function automatic longint clip_resp(longint v);
        if (v < 0)
            return 0;
        return (v > RMAX) ? RMAX : v;
    endfunction

    function automatic longint floor_shift(longint v);
        return (v < 0) ? -1 : (v >>> F);
    endfunction

    function automatic force_item_t predict_force(logic [15:0] raw);
        force_item_t res;
        longint d, b, r, t, t2, t3, h1, h3, k, f, ff, g, contact;
        d = longint'($signed(raw));
        b = (blend > (max_dist >> 1)) ? (max_dist >> 1) : blend;
        r = max_dist - b;
        contact = 3 * flimit;
        if (d >= max_dist)
        begin
            res.response = '0;
            res.region = REGION_FAR;
        end
        else if (d <= 0)
        begin
            res.response = RESP_W'(clip_resp(contact));
            res.region = REGION_CONTACT;
        end
        else if (d > r || d <= b)
        begin
            // both blends share the Hermite basis
            longint u;
            u = (d > r) ? d - r : d;
            t = (b > 0 && u > 0) ? ((u << F) / b) : 0;
            t2 = (t * t) >>> F;
            t3 = (t2 * t) >>> F;
            h1 = 2 * t3 - 3 * t2 + (64'd1 << F);
            if (d > r)
            begin
                h3 = t3 - 2 * t2 + t;
                f = reciprocal(r);
                ff = (f * f) >>> F;
                if (ff > (64'd1 << 40))
                    ff = 64'd1 << 40;
                g = (ff * b) >>> F;
                res.response = RESP_W'(clip_resp(floor_shift(f * h1 - g * h3)));
                res.region = REGION_OUTER;
            end
            else
            begin
                k = 4 * t2 - 3 * t3;
                f = reciprocal(b);
                res.response = RESP_W'(clip_resp(floor_shift(contact * h1 + f * k)));
                res.region = REGION_INNER;
            end
        end
        else
        begin
            res.response = RESP_W'(clip_resp(reciprocal(d)));
            res.region = REGION_INVERSE;
        end
        return res;
    endfunction

    // register write, block idle
    task automatic write_reg(cfg_index_t idx, longint value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_DISTANCE: max_dist = value & 16'h7FFF;
            CFG_BLEND_WIDTH: blend = value & 16'h3FFF;
            default: flimit = value & 18'h3FFFF;
        endcase
    endtask

    task automatic set_curve(longint m, longint b, longint fl);
        write_reg(CFG_MAX_DISTANCE, m);
        write_reg(CFG_BLEND_WIDTH, b);
        write_reg(CFG_FORCE_LIMIT, fl);
    endtask

    // one item over the input handshake; valid stays up for a following item
    task automatic send_distance(logic [15:0] distance);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= distance;
        expected_q.push_back(predict_force(distance));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // distance biased toward region edges of the current curve
    function automatic logic [15:0] pick_distance();
        longint b, base;
        b = (blend > (max_dist >> 1)) ? (max_dist >> 1) : blend;
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: base = max_dist;
            2: base = max_dist - b;
            3: base = b;
            4: base = 0;
            default: return 16'($urandom_range(max_dist > 0 ? max_dist : 1));
        endcase
        return 16'(base + longint'($urandom_range(40)) - 20);
    endfunction

    task automatic test_directed_edges;
        logic [15:0] pts[$];
        pts = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 16'd409, 16'd410,
                16'd411, 16'd1000, 16'd4096, 16'd7781, 16'd7782, 16'd7783, 16'd8000,
                16'd8191, 16'd8192, 16'd8193, 16'h7FFF, 16'h5555, 16'hAAAA};
        foreach (pts[i])
            send_distance(pts[i]);
        drain();
    endtask

    logic [15:0] pts_tmp[5] = '{16'd1, 16'd100, 16'd16383, 16'd16384, 16'd32766};

    task automatic test_extreme_configs;
        set_curve(0, 0, 0);
        send_distance(16'h0000);
        send_distance(16'hFFFF);
        send_distance(16'd5);
        drain();
        set_curve(32767, 16383, 262143);
        foreach (pts_tmp[i])
            send_distance(pts_tmp[i]);
        drain();
        set_curve(100, 0, 1);
        for (int i = 0; i < 6; i++)
            send_distance(16'(i));
        drain();
        set_curve(1, 1, 5);
        send_distance(16'd0);
        send_distance(16'd1);
        drain();
    endtask

    task automatic test_random_phase(int idle, int stall, int n);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        set_curve($urandom_range(32767), $urandom_range(16383), $urandom_range(262143));
        for (int i = 0; i < n; i++)
            send_distance(pick_distance());
        // pause until the pipeline has emptied
        drain();
    endtask

    // receiver: random stall, compare each item
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result item %h", m_tdata);
                fails++;
            end
            else
            begin
                force_item_t e;
                e = expected_q.pop_front();
                if (m_tdata[19:0] !== e.response)
                begin
                    $error("response expected %0d actual %0d", e.response, m_tdata[19:0]);
                    fails++;
                end
                if (m_tuser !== e.region)
                begin
                    $error("region expected %0d actual %0d", e.region, m_tuser);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        max_dist = 8192;
        blend = 410;
        flimit = 12288;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_edges();
        test_extreme_configs();
        test_random_phase(0, 0, 150);
        test_random_phase(53, 0, 150);
        test_random_phase(0, 53, 150);
        test_random_phase(17, 17, 150);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
